// ----- rtl/tpc_pkg.sv -----
package tpc_pkg;

	// Sizes
	localparam int STORE_DEPTH = 16384;
	localparam int PACKET_MAX  = 4096;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
	localparam int OFF_W       = $clog2(PACKET_MAX + 1);

	// Field widths
	localparam int ACT_W    = 3;
	localparam int BYTE_W   = 8;
	localparam int TAG_W    = 8;
	localparam int STAT_W   = 2;
	localparam int PHASE_W  = 2;
	localparam int TMO_W    = 16;
	localparam int MARKER_W = 32;
	localparam int RECENT_W = 24;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// Actions
	localparam logic [ACT_W-1:0] ACT_START = 3'd0;
	localparam logic [ACT_W-1:0] ACT_BYTE  = 3'd1;
	localparam logic [ACT_W-1:0] ACT_TICK  = 3'd2;
	localparam logic [ACT_W-1:0] ACT_READ  = 3'd3;
	localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd4;

	// Status codes
	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_NOCOLL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_DROP    = 2'd2;
	localparam logic [STAT_W-1:0] ST_NOREAD  = 2'd3;

	// Collection phase
	localparam logic [PHASE_W-1:0] PH_IDLE    = 2'd0;
	localparam logic [PHASE_W-1:0] PH_COLLECT = 2'd1;
	localparam logic [PHASE_W-1:0] PH_DONE    = 2'd2;
	localparam logic [PHASE_W-1:0] PH_ERROR   = 2'd3;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FINAL_ID = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MARKER   = 2'd2;

	// Register reset values
	localparam logic [TMO_W-1:0]    TIMEOUT_RST  = 16'd5000;
	localparam logic [TAG_W-1:0]    FINAL_ID_RST = 8'h08;
	localparam logic [MARKER_W-1:0] MARKER_RST   = 32'h464F_4F46; // "FOOF"

	localparam logic [TMO_W-1:0] ELAPSED_MAX = '1;

endpackage

// ----- rtl/template_packet_collector.sv -----
// Template packet collector: builds a template store from packet bytes.
// Path: an accepted word is held in s1; its result word is registered in s2 when s1 moves on.
// Throughput: one word per cycle while out_stall does not hold s2; the single write/read port of
// the template store is no limit, since each word touches it at most once.
// Reset: arst_n low clears phase to idle, counters, marker state and the registers
// to their defaults; the template store itself is not cleared (reads stay below the count).
module template_packet_collector
	import tpc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,

	// configuration write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,

	// input channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [ACT_W-1:0]      action,
	input  logic [BYTE_W-1:0]     data_byte,
	input  logic [TAG_W-1:0]      packet_tag,
	input  logic                  first_of_packet,
	input  logic                  last_of_packet,
	input  logic [ADDR_W-1:0]     read_address,

	// output channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [STAT_W-1:0]     status,
	output logic [PHASE_W-1:0]    collect_state,
	output logic [CNT_W-1:0]      stored_count,
	output logic                  marker_seen,
	output logic [BYTE_W-1:0]     read_byte,
	output logic                  read_ok
);

	// ---------------- configuration registers ----------------
	logic [TMO_W-1:0]    timeout_q;
	logic [TAG_W-1:0]    final_id_q;
	logic [MARKER_W-1:0] marker_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q  <= TIMEOUT_RST;
			final_id_q <= FINAL_ID_RST;
			marker_q   <= MARKER_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TIMEOUT:  timeout_q  <= cfg_data[TMO_W-1:0];
				REG_FINAL_ID: final_id_q <= cfg_data[TAG_W-1:0];
				REG_MARKER:   marker_q   <= cfg_data[MARKER_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- handshake ----------------
	// s1 holds the accepted word; s2 holds the result word.
	// The whole state update happens when s1 moves into s2.
	logic vld_s1, vld_s2;
	logic adv, move, in_acc;

	assign adv      = !vld_s2 || !out_stall;
	assign move     = vld_s1 && adv;
	assign in_stall = vld_s1 && !adv;
	assign in_acc   = in_valid && !in_stall;

	// ---------------- input register ----------------
	logic [ACT_W-1:0]  act_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic [TAG_W-1:0]  tag_s1;
	logic              first_s1;
	logic              last_s1;
	logic [ADDR_W-1:0] addr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_acc) begin
			vld_s1 <= 1'b1;
		end else if (move) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			act_s1   <= action;
			byte_s1  <= data_byte;
			tag_s1   <= packet_tag;
			first_s1 <= first_of_packet;
			last_s1  <= last_of_packet;
			addr_s1  <= read_address;
		end
	end

	// ---------------- collection state ----------------
	logic [PHASE_W-1:0]  phase_q;
	logic [CNT_W-1:0]    count_q;
	logic                term_q;
	logic [TMO_W-1:0]    elapsed_q;
	logic [RECENT_W-1:0] recent_q;
	logic [OFF_W-1:0]    offset_q;
	logic                closed_q;

	logic [PHASE_W-1:0]  phase_d;
	logic [CNT_W-1:0]    count_d;
	logic                term_d;
	logic [TMO_W-1:0]    elapsed_d;
	logic [RECENT_W-1:0] recent_d;
	logic [OFF_W-1:0]    offset_d;
	logic                closed_d;
	logic [STAT_W-1:0]   stat_d;
	logic                rok_d;
	logic                wr_en;

	// packet context after a possible packet open
	logic [RECENT_W-1:0] rec_v;
	logic [OFF_W-1:0]    off_v;
	logic                closed_v;
	logic                store_full;
	logic                hit;

	always_comb begin
		phase_d   = phase_q;
		count_d   = count_q;
		term_d    = term_q;
		elapsed_d = elapsed_q;
		recent_d  = recent_q;
		offset_d  = offset_q;
		closed_d  = closed_q;
		stat_d    = ST_OK;
		rok_d     = 1'b0;
		wr_en     = 1'b0;

		rec_v      = first_s1 ? '0 : recent_q;
		off_v      = first_s1 ? '0 : offset_q;
		closed_v   = first_s1 ? 1'b0 : closed_q;
		store_full = count_q >= CNT_W'(STORE_DEPTH);
		hit        = (off_v >= OFF_W'(3)) && ({rec_v, byte_s1} == marker_q);

		case (act_s1)
			ACT_START: begin
				phase_d   = PH_COLLECT;
				count_d   = '0;
				term_d    = 1'b0;
				elapsed_d = '0;
				recent_d  = '0;
				offset_d  = '0;
				closed_d  = 1'b0;
			end
			ACT_BYTE: begin
				if (phase_q != PH_COLLECT) begin
					stat_d = ST_NOCOLL;
				end else if (tag_s1 == final_id_q) begin
					// final packet: done, nothing stored, no timeout check
					term_d  = 1'b1;
					phase_d = PH_DONE;
				end else if (first_s1 && store_full) begin
					// new packet on a full store ends collection
					recent_d = '0;
					offset_d = '0;
					closed_d = 1'b1;
					phase_d  = PH_DONE;
					stat_d   = ST_DROP;
				end else begin
					recent_d = rec_v;
					offset_d = off_v;
					closed_d = closed_v;
					if (closed_v || off_v >= OFF_W'(PACKET_MAX)) begin
						stat_d = ST_DROP;
					end else begin
						if (!store_full) begin
							wr_en   = 1'b1;
							count_d = count_q + CNT_W'(1);
						end else begin
							stat_d = ST_DROP;
						end
						recent_d = {rec_v[RECENT_W-BYTE_W-1:0], byte_s1};
						offset_d = off_v + OFF_W'(1);
						if (hit) begin
							term_d   = 1'b1;
							phase_d  = PH_DONE;
							closed_d = 1'b1;
						end
					end
					// timeout is checked at packet end only
					if (last_s1 && phase_d == PH_COLLECT && elapsed_q > timeout_q) begin
						phase_d = (count_d != '0) ? PH_DONE : PH_ERROR;
					end
				end
			end
			ACT_TICK: begin
				if (elapsed_q != ELAPSED_MAX) begin
					elapsed_d = elapsed_q + TMO_W'(1);
				end
			end
			ACT_READ: begin
				if (phase_q == PH_DONE && count_q != '0 &&
				    CNT_W'(addr_s1) < count_q) begin
					rok_d = 1'b1;
				end else begin
					stat_d = ST_NOREAD;
				end
			end
			ACT_CLEAR: begin
				phase_d   = PH_IDLE;
				count_d   = '0;
				term_d    = 1'b0;
				elapsed_d = '0;
				recent_d  = '0;
				offset_d  = '0;
				closed_d  = 1'b0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			count_q   <= '0;
			term_q    <= 1'b0;
			elapsed_q <= '0;
			recent_q  <= '0;
			offset_q  <= '0;
			closed_q  <= 1'b0;
		end else if (move) begin
			phase_q   <= phase_d;
			count_q   <= count_d;
			term_q    <= term_d;
			elapsed_q <= elapsed_d;
			recent_q  <= recent_d;
			offset_q  <= offset_d;
			closed_q  <= closed_d;
		end
	end

	// ---------------- template store ----------------
	// One port per cycle: a byte word writes, a read word reads; never both.
	logic [BYTE_W-1:0] store_mem [STORE_DEPTH];
	logic [BYTE_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (move && wr_en) begin
			store_mem[count_q[ADDR_W-1:0]] <= byte_s1;
		end
		if (move && rok_d) begin
			rd_q <= store_mem[addr_s1];
		end
	end

	// ---------------- result register ----------------
	logic [STAT_W-1:0]  status_s2;
	logic [PHASE_W-1:0] phase_s2;
	logic [CNT_W-1:0]   count_s2;
	logic               term_s2;
	logic               rok_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			status_s2 <= stat_d;
			phase_s2  <= phase_d;
			count_s2  <= count_d;
			term_s2   <= term_d;
			rok_s2    <= rok_d;
		end
	end

	assign out_valid     = vld_s2;
	assign status        = status_s2;
	assign collect_state = phase_s2;
	assign stored_count  = count_s2;
	assign marker_seen   = term_s2;
	assign read_ok       = rok_s2;
	assign read_byte     = rok_s2 ? rd_q : '0;

`ifndef SYNTHESIS
	a_read_only_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && read_ok |-> collect_state == PH_DONE && status == ST_OK &&
			stored_count != '0)
		else $error("read_ok outside a completed nonempty template");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(STORE_DEPTH))
		else $error("stored count beyond store depth");

	a_offset_bound: assert property (@(posedge clk) disable iff (!arst_n)
		offset_q <= OFF_W'(PACKET_MAX))
		else $error("packet offset beyond packet limit");

	a_no_write_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		move && wr_en |-> count_q < CNT_W'(STORE_DEPTH))
		else $error("store write on a full store");

	a_state_holds_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!move |=> $stable(count_q) && $stable(phase_q))
		else $error("collection state changed without a word moving");
`endif

endmodule

// ----- test/template_packet_collector_test.sv -----
module template_packet_collector_test;
	import tpc_pkg::*;

	// Action codes the block ignores
	localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd5;
	localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;
	// Register index with no register behind it
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	// Result word comes back through the block's s1 and s2 registers; margin on top
	localparam int HOLD_CYCLES  = 8;
	// Cycles with no handshake on either side before the run is called hung
	localparam int QUIET_LIMIT  = 2000;
	localparam int RANDOM_WORDS = 1000;

	typedef struct packed {
		logic [ACT_W-1:0]  act;
		logic [BYTE_W-1:0] data;
		logic [TAG_W-1:0]  tag;
		logic              first_b;
		logic              last_b;
		logic [ADDR_W-1:0] addr;
	} in_word_t;

	typedef struct packed {
		logic [STAT_W-1:0]  st;
		logic [PHASE_W-1:0] ph;
		logic [CNT_W-1:0]   cnt;
		logic               seen;
		logic [BYTE_W-1:0]  rd;
		logic               rok;
	} res_word_t;

	// ---------------------------------------------------------------
	// Clock, reset and block ports
	// ---------------------------------------------------------------
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	logic                  in_valid        = 1'b0;
	logic                  in_stall;
	logic [ACT_W-1:0]      action          = '0;
	logic [BYTE_W-1:0]     data_byte       = '0;
	logic [TAG_W-1:0]      packet_tag      = '0;
	logic                  first_of_packet = 1'b0;
	logic                  last_of_packet  = 1'b0;
	logic [ADDR_W-1:0]     read_address    = '0;

	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [STAT_W-1:0]     status;
	logic [PHASE_W-1:0]    collect_state;
	logic [CNT_W-1:0]      stored_count;
	logic                  marker_seen;
	logic [BYTE_W-1:0]     read_byte;
	logic                  read_ok;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	template_packet_collector DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.data_byte(data_byte),
		.packet_tag(packet_tag),
		.first_of_packet(first_of_packet),
		.last_of_packet(last_of_packet),
		.read_address(read_address),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.collect_state(collect_state),
		.stored_count(stored_count),
		.marker_seen(marker_seen),
		.read_byte(read_byte),
		.read_ok(read_ok)
	);

	// ---------------------------------------------------------------
	// Collector model: registers and collection state as the block holds them
	// ---------------------------------------------------------------
	logic [TMO_W-1:0]    tmo_limit  = TIMEOUT_RST;
	logic [TAG_W-1:0]    final_tag  = FINAL_ID_RST;
	logic [MARKER_W-1:0] marker_pat = MARKER_RST;

	// Template store; only entries below tpl_count are ever read back
	logic [BYTE_W-1:0]   tpl_mem [STORE_DEPTH];
	int                  tpl_count   = 0;
	logic [PHASE_W-1:0]  coll_phase  = PH_IDLE;
	logic                marker_flag = 1'b0;
	int                  ms_elapsed  = 0;
	logic [RECENT_W-1:0] scan_tail   = '0;    // last three scanned bytes of this packet
	int                  pkt_pos     = 0;     // bytes scanned in this packet, stops at PACKET_MAX
	logic                pkt_shut    = 1'b0;  // rest of this packet is dropped

	res_word_t pending_results [$];
	res_word_t want_word;
	int        mismatches   = 0;
	int        words_sent   = 0;
	int        quiet_cycles = 0;

	// sender burst shaping
	int burst_left = 0;
	int gap_max    = 6;

	// receiver stall pattern: a 32-bit mask walked by a counter, redrawn each lap
	logic [31:0] stall_mask = '0;
	logic [4:0]  stall_pos  = '0;

	function automatic void restart_template();
		tpl_count   = 0;
		marker_flag = 1'b0;
		ms_elapsed  = 0;
		scan_tail   = '0;
		pkt_pos     = 0;
		pkt_shut    = 1'b0;
	endfunction

	// Advance the model by one input word and return the result word it gives.
	function automatic res_word_t predict_result(in_word_t w);
		res_word_t r;
		logic      hit;
		logic      open_on_full;
		r = '0;
		case (w.act)
			ACT_START: begin
				restart_template();
				coll_phase = PH_COLLECT;
			end
			ACT_BYTE: begin
				if (coll_phase != PH_COLLECT) begin
					r.st = ST_NOCOLL;
				end else if (w.tag == final_tag) begin
					// final packet: done, nothing stored, no timeout check
					marker_flag = 1'b1;
					coll_phase  = PH_DONE;
				end else begin
					open_on_full = 1'b0;
					if (w.first_b) begin
						scan_tail = '0;
						pkt_pos   = 0;
						pkt_shut  = 1'b0;
						if (tpl_count >= STORE_DEPTH) begin
							// a new packet on a full store ends collection
							pkt_shut     = 1'b1;
							coll_phase   = PH_DONE;
							open_on_full = 1'b1;
							r.st         = ST_DROP;
						end
					end
					if (!open_on_full) begin
						if (pkt_shut || pkt_pos >= PACKET_MAX) begin
							r.st = ST_DROP;
						end else begin
							// marker must lie wholly inside this packet
							hit = (pkt_pos >= 3) && ({scan_tail, w.data} == marker_pat);
							if (tpl_count < STORE_DEPTH) begin
								tpl_mem[tpl_count] = w.data;
								tpl_count++;
							end else begin
								r.st = ST_DROP;  // full store: still scanned
							end
							scan_tail = {scan_tail[RECENT_W-BYTE_W-1:0], w.data};
							pkt_pos++;
							if (hit) begin
								marker_flag = 1'b1;
								coll_phase  = PH_DONE;
								pkt_shut    = 1'b1;
							end
						end
						if (w.last_b && coll_phase == PH_COLLECT && ms_elapsed > int'(tmo_limit))
							coll_phase = (tpl_count > 0) ? PH_DONE : PH_ERROR;
					end
				end
			end
			ACT_TICK: begin
				if (ms_elapsed < int'(ELAPSED_MAX))
					ms_elapsed++;
			end
			ACT_READ: begin
				if (coll_phase == PH_DONE && tpl_count > 0 && int'(w.addr) < tpl_count) begin
					r.rd  = tpl_mem[w.addr];
					r.rok = 1'b1;
				end else begin
					r.st = ST_NOREAD;
				end
			end
			ACT_CLEAR: begin
				restart_template();
				coll_phase = PH_IDLE;
			end
			default: ;
		endcase
		r.ph   = coll_phase;
		r.cnt  = CNT_W'(tpl_count);
		r.seen = marker_flag;
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Word builders; fields the action does not use are random
	// ---------------------------------------------------------------
	function automatic in_word_t noise_word();
		in_word_t w;
		w.act     = ACT_W'($urandom_range(0, 7));
		w.data    = BYTE_W'($urandom);
		w.tag     = TAG_W'($urandom);
		w.first_b = 1'($urandom);
		w.last_b  = 1'($urandom);
		w.addr    = ADDR_W'($urandom);
		return w;
	endfunction

	function automatic in_word_t simple_word(logic [ACT_W-1:0] act);
		in_word_t w;
		w     = noise_word();
		w.act = act;
		return w;
	endfunction

	function automatic in_word_t byte_word(logic [BYTE_W-1:0] b, logic [TAG_W-1:0] tag,
			logic first_b, logic last_b);
		in_word_t w;
		w         = noise_word();
		w.act     = ACT_BYTE;
		w.data    = b;
		w.tag     = tag;
		w.first_b = first_b;
		w.last_b  = last_b;
		return w;
	endfunction

	function automatic in_word_t read_word(logic [ADDR_W-1:0] addr);
		in_word_t w;
		w      = noise_word();
		w.act  = ACT_READ;
		w.addr = addr;
		return w;
	endfunction

	function automatic logic [BYTE_W-1:0] marker_byte(int k);
		return marker_pat[8*(3-k) +: 8];
	endfunction

	// Data biased toward the marker's own bytes so markers form by chance too
	function automatic logic [BYTE_W-1:0] pick_data();
		if ($urandom_range(0, 9) < 6)
			return marker_byte($urandom_range(0, 3));
		return BYTE_W'($urandom);
	endfunction

	function automatic logic [TAG_W-1:0] pick_tag();
		if ($urandom_range(0, 11) == 0)
			return final_tag;
		return TAG_W'($urandom);
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// ---------------------------------------------------------------
	// Driving
	// ---------------------------------------------------------------

	// Send one word; returns right after the edge that accepted it.
	// Valid stays high on return so back-to-back words need no extra step.
	task automatic send_word(input in_word_t w);
		int gap;
		if (burst_left == 0) begin
			gap        = $urandom_range(0, gap_max);
			burst_left = $urandom_range(1, 32);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid        <= 1'b1;
		action          <= w.act;
		data_byte       <= w.data;
		packet_tag      <= w.tag;
		first_of_packet <= w.first_b;
		last_of_packet  <= w.last_b;
		read_address    <= w.addr;
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
		pending_results.push_back(predict_result(w));
		words_sent++;
	endtask

	// Hold the input off until every pending result word has come back.
	// Always lets one edge pass so valid is not driven twice in one step.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_TIMEOUT:  tmo_limit  = value[TMO_W-1:0];
			REG_FINAL_ID: final_tag  = value[TAG_W-1:0];
			REG_MARKER:   marker_pat = value[MARKER_W-1:0];
			default: ;
		endcase
	endtask

	task automatic send_packet(input int len, input logic [TAG_W-1:0] tag,
			input bit random_fill, input logic [BYTE_W-1:0] fill_byte);
		for (int i = 0; i < len; i++)
			send_word(byte_word(random_fill ? BYTE_W'($urandom) : fill_byte, tag,
				i == 0, i == len - 1));
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// Everything sent before a start: bytes refused, reads unavailable,
	// ticks and spare action codes change nothing visible.
	task automatic test_idle_actions();
		send_word(byte_word('1, '0, 1'b1, 1'b1));
		send_word(read_word('1));
		send_word(simple_word(ACT_TICK));
		for (int a = ACT_SPARE_LO; a <= ACT_SPARE_HI; a++)
			send_word(simple_word(ACT_W'(a)));
		send_word(simple_word(ACT_CLEAR));
	endtask

	// Marker inside one packet completes collection; reads inside and past the count.
	task automatic test_marker_capture();
		send_word(simple_word(ACT_START));
		send_word(byte_word(8'h41, 8'h01, 1'b1, 1'b0));
		for (int k = 0; k < 4; k++)
			send_word(byte_word(marker_byte(k), 8'h01, 1'b0, 1'b0));
		send_word(byte_word(8'h42, 8'h01, 1'b0, 1'b1));  // after completion: refused
		send_word(read_word('0));
		send_word(read_word(ADDR_W'(tpl_count - 1)));
		send_word(read_word(ADDR_W'(tpl_count)));
		// restart from complete, then restart while collecting
		send_word(simple_word(ACT_START));
		send_word(byte_word(8'h00, 8'h02, 1'b1, 1'b0));
		send_word(simple_word(ACT_START));
		send_word(read_word('0));
	endtask

	// Marker split over two packets must not match; bytes with no packet
	// opened since start form one implicit packet; final tag ends collection.
	task automatic test_split_marker();
		send_word(simple_word(ACT_START));
		send_word(byte_word(marker_byte(0), 8'h03, 1'b1, 1'b0));
		send_word(byte_word(marker_byte(1), 8'h03, 1'b0, 1'b1));
		send_word(byte_word(marker_byte(2), 8'h03, 1'b1, 1'b0));
		send_word(byte_word(marker_byte(3), 8'h03, 1'b0, 1'b1));
		send_word(simple_word(ACT_START));
		for (int k = 0; k < 4; k++)
			send_word(byte_word(marker_byte(k), 8'h03, 1'b0, 1'b0));
		send_word(simple_word(ACT_START));
		send_word(byte_word(8'h55, final_tag, 1'b1, 1'b1));
		send_word(read_word('0));
	endtask

	// Timeout only bites at packet end and only once elapsed exceeds the limit.
	task automatic test_timeout_check();
		write_reg(REG_TIMEOUT, '0);
		send_word(simple_word(ACT_START));
		send_word(byte_word(8'h11, 8'h04, 1'b1, 1'b1));  // elapsed equals limit: no effect
		send_word(simple_word(ACT_TICK));
		send_word(byte_word(8'h22, 8'h04, 1'b1, 1'b0));
		send_word(byte_word(8'h33, 8'h04, 1'b0, 1'b1));  // now past the limit
		send_word(read_word(ADDR_W'(1)));
	endtask

	// Register extremes: all-zero and all-one markers and final tags, an all-one timeout,
	// writes to the unused index, then back to the reset values.
	task automatic test_register_extremes();
		write_reg(REG_FINAL_ID, {$urandom} & ~32'hFF);
		write_reg(REG_MARKER, 32'h0000_0000);
		write_reg(REG_TIMEOUT, {$urandom} | 32'hFFFF);
		write_reg(REG_SPARE, $urandom);
		send_word(simple_word(ACT_START));
		send_packet(5, 8'h01, 1'b0, 8'h00);
		send_word(simple_word(ACT_START));
		send_word(byte_word(8'hFF, 8'h00, 1'b1, 1'b1));

		write_reg(REG_FINAL_ID, {$urandom} | 32'hFF);
		write_reg(REG_MARKER, 32'hFFFF_FFFF);
		send_word(simple_word(ACT_START));
		send_packet(4, 8'h00, 1'b0, 8'hFF);
		send_word(simple_word(ACT_START));
		send_word(byte_word(8'h00, 8'hFF, 1'b0, 1'b0));

		write_reg(REG_TIMEOUT, {$urandom} & ~32'hFFFF | TIMEOUT_RST);
		write_reg(REG_FINAL_ID, FINAL_ID_RST);
		write_reg(REG_MARKER, MARKER_RST);
	endtask

	// New register settings between sessions; markers built from two byte
	// values so that the biased data hits them often.
	task automatic retune_registers();
		logic [MARKER_W-1:0] m;
		logic [BYTE_W-1:0]   a;
		logic [BYTE_W-1:0]   b;
		logic [TMO_W-1:0]    tmo;
		a = BYTE_W'($urandom);
		b = BYTE_W'($urandom);
		for (int k = 0; k < 4; k++)
			m[8*k +: 8] = $urandom_range(0, 1) ? a : b;
		if ($urandom_range(0, 3) == 0)
			m = $urandom;
		case ($urandom_range(0, 4))
			0:       tmo = '0;
			1, 2:    tmo = TMO_W'($urandom_range(0, 6));
			3:       tmo = ELAPSED_MAX;
			default: tmo = TMO_W'($urandom);
		endcase
		write_reg(REG_TIMEOUT, {16'($urandom), tmo});
		if ($urandom_range(0, 1) == 0)
			write_reg(REG_FINAL_ID, $urandom);
		write_reg(REG_MARKER, m);
		if ($urandom_range(0, 7) == 0)
			write_reg(REG_SPARE, $urandom);
	endtask

	// Mostly well-formed sessions: start, a few short packets with random
	// content and tags, ticks in between, then reads; noise mixed in.
	task automatic test_random_sessions();
		int       goal;
		int       n_pk;
		int       len;
		int       mk_at;
		in_word_t w;
		goal = words_sent + RANDOM_WORDS;
		while (words_sent < goal) begin
			if ($urandom_range(0, 5) == 0)
				retune_registers();
			if ($urandom_range(0, 9) == 0)
				send_word(noise_word());
			send_word(simple_word(ACT_START));
			n_pk = $urandom_range(1, 5);
			for (int p = 0; p < n_pk; p++) begin
				len   = $urandom_range(1, 14);
				// sometimes plant the marker, possibly running past the packet end
				mk_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, len - 1) : -1;
				for (int i = 0; i < len; i++) begin
					w = byte_word(pick_data(), pick_tag(),
						i == 0 && $urandom_range(0, 9) != 0,
						i == len - 1 && $urandom_range(0, 9) != 0);
					if (mk_at >= 0 && i >= mk_at && i < mk_at + 4)
						w.data = marker_byte(i - mk_at);
					send_word(w);
					if ($urandom_range(0, 7) == 0)
						send_word(simple_word(ACT_TICK));
					if ($urandom_range(0, 29) == 0)
						send_word(noise_word());
				end
			end
			repeat ($urandom_range(1, 5)) begin
				if (tpl_count > 0 && $urandom_range(0, 4) != 0)
					send_word(read_word(ADDR_W'($urandom_range(0, tpl_count))));
				else
					send_word(read_word(ADDR_W'($urandom)));
			end
			if ($urandom_range(0, 3) == 0)
				send_word(simple_word(ACT_CLEAR));
		end
	endtask

	// ---------------------------------------------------------------
	// Receiver stall pattern; an all-zero mask gives stall-free stretches
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (stall_pos == '0)
			stall_mask <= ($urandom_range(0, 3) == 0) ? '0 : ($urandom & $urandom);
		stall_pos <= stall_pos + 5'd1;
		out_stall <= stall_mask[stall_pos];
	end

	// ---------------------------------------------------------------
	// Result checker: each accepted result word against the oldest expectation
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result word arrived with nothing pending");
				mismatches++;
			end else begin
				want_word = pending_results.pop_front();
				check_field("status", want_word.st, status);
				check_field("collect_state", want_word.ph, collect_state);
				check_field("stored_count", want_word.cnt, stored_count);
				check_field("marker_seen", want_word.seen, marker_seen);
				check_field("read_byte", want_word.rd, read_byte);
				check_field("read_ok", want_word.rok, read_ok);
			end
		end
	end

	// Watchdog: too long with no handshake on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_actions();
		test_marker_capture();
		test_split_marker();
		test_timeout_check();
		test_register_extremes();
		test_random_sessions();
		wait_drained();
		repeat (HOLD_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
